// File: rtl/bpl_pkg.sv
package bpl_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int POS_W      = 5;
	localparam int FUNC_W     = 3;
	// compare width wide enough for position and count + 1
	localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [IDX_W-1:0]      idx_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_INS_FRONT = 3'd0,
		FN_APPEND    = 3'd1,
		FN_INS_POS   = 3'd2,
		FN_DEL_FRONT = 3'd3,
		FN_POP_BACK  = 3'd4,
		FN_DEL_POS   = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_UNDER  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// one decoded operation, broadcast to every cell
	typedef struct packed {
		logic    ins;
		logic    del;
		idx_t    idx;
		status_t status;
	} cmd_t;

endpackage

// File: rtl/bpl_cell.sv
// One slot of the list. Shifts toward the tail on insert, toward the front on delete.
module bpl_cell (
	input  logic          clk,
	input  bpl_pkg::idx_t slot,
	input  bpl_pkg::cmd_t cmd,
	input  logic          step,
	input  bpl_pkg::word_t value,
	input  bpl_pkg::word_t left,
	input  bpl_pkg::word_t right,
	output bpl_pkg::word_t word,
	output bpl_pkg::word_t tap
);

	bpl_pkg::word_t word_q;

	always_ff @(posedge clk) begin
		if (step && cmd.ins) begin
			if (slot == cmd.idx) begin
				word_q <= value;
			end else if (slot > cmd.idx) begin
				word_q <= left;
			end
		end else if (step && cmd.del) begin
			if (slot >= cmd.idx) begin
				word_q <= right;
			end
		end
	end

	assign word = word_q;
	// removed word leaves through the tap of the addressed slot
	assign tap  = (cmd.del && slot == cmd.idx) ? word_q : '0;

endmodule

// File: rtl/bpl_dec.sv
// Turns func/position and the current count into a checked command.
module bpl_dec (
	input  logic [bpl_pkg::FUNC_W-1:0] func,
	input  logic [bpl_pkg::POS_W-1:0]  position,
	input  bpl_pkg::cnt_t              held,
	output bpl_pkg::cmd_t              cmd
);

	logic [bpl_pkg::CMP_W-1:0] pos_x;
	logic [bpl_pkg::CMP_W-1:0] held_x;
	logic [bpl_pkg::POS_W-1:0] pos_m1;
	bpl_pkg::cnt_t             held_m1;
	logic                      full;
	logic                      empty;

	assign pos_x   = bpl_pkg::CMP_W'(position);
	assign held_x  = bpl_pkg::CMP_W'(held);
	assign pos_m1  = position - bpl_pkg::POS_W'(1);
	assign held_m1 = held - bpl_pkg::CNT_W'(1);
	assign full    = (held == bpl_pkg::CNT_W'(bpl_pkg::DEPTH));
	assign empty   = (held == '0);

	always_comb begin
		cmd.ins    = 1'b0;
		cmd.del    = 1'b0;
		cmd.idx    = '0;
		cmd.status = bpl_pkg::ST_OK;
		unique case (bpl_pkg::func_t'(func)) inside
			bpl_pkg::FN_INS_FRONT, bpl_pkg::FN_APPEND: begin
				if (full) begin
					cmd.status = bpl_pkg::ST_FULL;
				end else begin
					cmd.ins = 1'b1;
					cmd.idx = (bpl_pkg::func_t'(func) == bpl_pkg::FN_APPEND) ?
						held[bpl_pkg::IDX_W-1:0] : '0;
				end
			end
			bpl_pkg::FN_INS_POS: begin
				if (pos_x == '0 || pos_x > held_x + bpl_pkg::CMP_W'(1)) begin
					cmd.status = bpl_pkg::ST_BADPOS;
				end else if (full) begin
					cmd.status = bpl_pkg::ST_FULL;
				end else begin
					cmd.ins = 1'b1;
					cmd.idx = pos_m1[bpl_pkg::IDX_W-1:0];
				end
			end
			bpl_pkg::FN_DEL_FRONT, bpl_pkg::FN_POP_BACK: begin
				if (empty) begin
					cmd.status = bpl_pkg::ST_UNDER;
				end else begin
					cmd.del = 1'b1;
					cmd.idx = (bpl_pkg::func_t'(func) == bpl_pkg::FN_POP_BACK) ?
						held_m1[bpl_pkg::IDX_W-1:0] : '0;
				end
			end
			bpl_pkg::FN_DEL_POS: begin
				if (empty) begin
					cmd.status = bpl_pkg::ST_UNDER;
				end else if (pos_x == '0 || pos_x > held_x) begin
					cmd.status = bpl_pkg::ST_BADPOS;
				end else begin
					cmd.del = 1'b1;
					cmd.idx = pos_m1[bpl_pkg::IDX_W-1:0];
				end
			end
			default: begin
				// unused codes: no change, status ok
			end
		endcase
	end

endmodule

// File: rtl/bounded_positional_list.sv
// Bounded ordered list of up to DEPTH signed words, held in a row of cells with
// the front word in cell 0. Each input word names one operation: insert at the
// front, append, insert at a 1-based position (1..count+1), delete the front,
// pop the back, or delete at a position (1..count). Every input word returns
// exactly one output word: the removed word (zero unless a delete succeeds), a
// status (ok, invalid position, underflow, full) and the count after the
// operation. The command is decoded combinationally; on the edge that accepts
// the word, the cells from the addressed slot onward shift toward their
// neighbor and the result is loaded into the output register. A new word is
// taken every clock as long as the output side keeps up; the output register
// is the only stall point. Contents of cells are not cleared at reset; only
// the count and the output valid flag are, so no stale word is ever returned.
module bounded_positional_list (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bpl_pkg::FUNC_W-1:0]    func,
	input  logic [bpl_pkg::POS_W-1:0]     position,
	input  logic signed [bpl_pkg::DATA_WIDTH-1:0] value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [bpl_pkg::DATA_WIDTH-1:0] data,
	output logic [1:0]                    status,
	output logic [bpl_pkg::CNT_W-1:0]     count
);

	bpl_pkg::cnt_t   held_q;
	bpl_pkg::cnt_t   held_nxt;
	bpl_pkg::cmd_t   cmd;
	logic            step;

	bpl_pkg::word_t  words [bpl_pkg::DEPTH];
	bpl_pkg::word_t  taps  [bpl_pkg::DEPTH];
	bpl_pkg::word_t  removed;

	logic            out_valid_q;
	bpl_pkg::word_t  data_q;
	bpl_pkg::status_t status_q;
	bpl_pkg::cnt_t   count_q;

	// output register frees up when empty or being drained this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	bpl_dec u_dec (
		.func     (func),
		.position (position),
		.held     (held_q),
		.cmd      (cmd)
	);

	// row of cells; cell 0's left and the last cell's right are never shifted in
	for (genvar i = 0; i < bpl_pkg::DEPTH; i++) begin : g_cell
		bpl_cell u_cell (
			.clk   (clk),
			.slot  (bpl_pkg::IDX_W'(i)),
			.cmd   (cmd),
			.step  (step),
			.value (value),
			.left  ((i == 0) ? value : words[(i == 0) ? 0 : i - 1]),
			.right ((i == bpl_pkg::DEPTH - 1) ? words[i] :
				words[(i == bpl_pkg::DEPTH - 1) ? i : i + 1]),
			.word  (words[i]),
			.tap   (taps[i])
		);
	end

	// only the addressed cell drives a nonzero tap
	always_comb begin
		removed = '0;
		for (int i = 0; i < bpl_pkg::DEPTH; i++) begin
			removed = removed | taps[i];
		end
	end

	always_comb begin
		held_nxt = held_q;
		if (cmd.ins) begin
			held_nxt = held_q + bpl_pkg::CNT_W'(1);
		end else if (cmd.del) begin
			held_nxt = held_q - bpl_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				held_q      <= held_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word; payload needs no reset
	always_ff @(posedge clk) begin
		if (step) begin
			data_q   <= cmd.del ? removed : '0;
			status_q <= cmd.status;
			count_q  <= held_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign status    = status_q;
	assign count     = count_q;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

	// func codes 6 and 7 are unused by the block: no change, status ok
	localparam logic [bpl_pkg::FUNC_W-1:0] FN_SPARE6 = 3'd6;
	localparam logic [bpl_pkg::FUNC_W-1:0] FN_SPARE7 = 3'd7;

	// idle time past the result register before the run closes
	localparam int TAIL_CYCLES = 16;

	typedef struct {
		bpl_pkg::word_t   data;
		bpl_pkg::status_t status;
		bpl_pkg::cnt_t    count;
	} list_result_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  in_valid;
	logic                                  in_ready;
	logic [bpl_pkg::FUNC_W-1:0]            func;
	logic [bpl_pkg::POS_W-1:0]             position;
	logic signed [bpl_pkg::DATA_WIDTH-1:0] value;
	logic                                  out_valid;
	logic                                  out_ready;
	logic signed [bpl_pkg::DATA_WIDTH-1:0] data;
	logic [1:0]                            status;
	logic [bpl_pkg::CNT_W-1:0]             count;

	// shadow copy of the list, front word at index 0
	bpl_pkg::word_t shadow_list[$];
	// results owed by the block, oldest first
	list_result_t   owed_results[$];
	int             mismatches = 0;
	int             sender_idle_pct = 0;
	int             receiver_idle_pct = 0;

	bounded_positional_list dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data      (data),
		.status    (status),
		.count     (count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case the handshake hangs
	initial begin
		#8_000_000;
		$display("** bounded_positional_list: FAILED **");
		$finish;
	end

	// Apply one operation to the shadow list and return what the block must answer.
	// Insert at position: 1..held+1 valid, checked before the full check.
	// Delete at position: empty list wins over the position check, then 1..held.
	function automatic list_result_t apply_list_op(logic [bpl_pkg::FUNC_W-1:0] op,
			logic [bpl_pkg::POS_W-1:0] pos, bpl_pkg::word_t val);
		list_result_t r;
		int n;
		int p;
		n = shadow_list.size();
		p = int'(pos);
		r.data = '0;
		r.status = bpl_pkg::ST_OK;
		case (op) inside
			bpl_pkg::FN_INS_FRONT, bpl_pkg::FN_APPEND, bpl_pkg::FN_INS_POS: begin
				if (op == bpl_pkg::FN_INS_POS && (p < 1 || p > n + 1))
					r.status = bpl_pkg::ST_BADPOS;
				else if (n >= bpl_pkg::DEPTH)
					r.status = bpl_pkg::ST_FULL;
				else if (op == bpl_pkg::FN_INS_FRONT)
					shadow_list.push_front(val);
				else if (op == bpl_pkg::FN_APPEND)
					shadow_list.push_back(val);
				else
					shadow_list.insert(p - 1, val);
			end
			bpl_pkg::FN_DEL_FRONT, bpl_pkg::FN_POP_BACK, bpl_pkg::FN_DEL_POS: begin
				if (n == 0)
					r.status = bpl_pkg::ST_UNDER;
				else if (op == bpl_pkg::FN_DEL_POS && (p < 1 || p > n))
					r.status = bpl_pkg::ST_BADPOS;
				else if (op == bpl_pkg::FN_DEL_FRONT)
					r.data = shadow_list.pop_front();
				else if (op == bpl_pkg::FN_POP_BACK)
					r.data = shadow_list.pop_back();
				else begin
					r.data = shadow_list[p - 1];
					shadow_list.delete(p - 1);
				end
			end
			default: ;
		endcase
		r.count = bpl_pkg::cnt_t'(shadow_list.size());
		return r;
	endfunction

	// Offer one word, with a random gap first, and hold it until taken.
	// Called just after the clock rises; returns just after the word is accepted.
	task automatic send_word(input logic [bpl_pkg::FUNC_W-1:0] op,
			input logic [bpl_pkg::POS_W-1:0] pos, input bpl_pkg::word_t val);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		position <= pos;
		value    <= val;
		do
			@(posedge clk);
		while (!in_ready);
		owed_results.push_back(apply_list_op(op, pos, val));
	endtask

	// stop sending until the block has answered everything
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random back-pressure at the current rate
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

	// compare each result word taken from the block against the oldest owed one
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result data=%h status=%0d count=%0d",
						$realtime, data, status, count);
			end else begin
				want = owed_results.pop_front();
				if (data !== want.data || status !== want.status ||
						count !== want.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: exp data=%h st=%0d cnt=%0d, got data=%h st=%0d cnt=%0d",
							$realtime, want.data, want.status, want.count,
							data, status, count);
				end
			end
		end
	end

	// every delete kind on an empty list underflows, even with a bad position
	task automatic test_underflow();
		send_word(bpl_pkg::FN_DEL_FRONT, 5'd1, 32'h0);
		send_word(bpl_pkg::FN_POP_BACK, 5'd1, 32'h0);
		send_word(bpl_pkg::FN_DEL_POS, 5'd0, 32'h0);
	endtask

	task automatic test_unused_codes();
		send_word(FN_SPARE6, 5'd31, 32'hffff_ffff);
		send_word(FN_SPARE7, 5'd31, 32'hffff_ffff);
	endtask

	// build the list up to DEPTH with every insert kind and the extreme words,
	// touching both ends of the insert position range on the way
	task automatic test_fill_list();
		int n;
		send_word(bpl_pkg::FN_INS_POS, 5'd1, 32'h8000_0000);
		send_word(bpl_pkg::FN_INS_FRONT, 5'd0, 32'h7fff_ffff);
		send_word(bpl_pkg::FN_APPEND, 5'd0, 32'hffff_ffff);
		send_word(bpl_pkg::FN_INS_POS, 5'd4, 32'h0000_0000);   // count+1: new tail
		send_word(bpl_pkg::FN_INS_POS, 5'd2, 32'h5555_5555);
		send_word(bpl_pkg::FN_INS_POS, 5'd0, 32'haaaa_aaaa);   // below range
		send_word(bpl_pkg::FN_INS_POS, 5'd7, 32'haaaa_aaaa);   // one past count+1
		n = shadow_list.size();
		while (n < bpl_pkg::DEPTH) begin
			case (n % 3)
				0:       send_word(bpl_pkg::FN_INS_FRONT, 5'($urandom), $urandom);
				1:       send_word(bpl_pkg::FN_APPEND, 5'($urandom), $urandom);
				default: send_word(bpl_pkg::FN_INS_POS, 5'($urandom_range(1, n + 1)),
					$urandom);
			endcase
			n = shadow_list.size();
		end
	endtask

	// full list: position is still checked first, then the full bound
	task automatic test_full_list();
		send_word(bpl_pkg::FN_INS_FRONT, 5'd0, 32'h1234_5678);
		send_word(bpl_pkg::FN_INS_POS, 5'd17, 32'h1234_5678);   // valid position, but full
		send_word(bpl_pkg::FN_INS_POS, 5'd18, 32'h1234_5678);   // bad position wins
	endtask

	task automatic test_deletes();
		send_word(bpl_pkg::FN_DEL_POS, 5'd17, 32'h0);   // past count
		send_word(bpl_pkg::FN_DEL_POS, 5'd16, 32'h0);   // tail
		send_word(bpl_pkg::FN_DEL_POS, 5'd0, 32'h0);
		send_word(bpl_pkg::FN_DEL_FRONT, 5'd0, 32'h0);
		send_word(bpl_pkg::FN_POP_BACK, 5'd0, 32'h0);
	endtask

	function automatic bpl_pkg::word_t pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'hffff_ffff;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Random mix. The list drifts between growing and shrinking phases so that
	// the count sweeps 0..DEPTH many times; positions are mostly in range with
	// some fully random ones for the bad-position paths.
	task automatic test_random_mix(input int n_items);
		bit grow;
		int held;
		int pick;
		logic [bpl_pkg::FUNC_W-1:0] op;
		logic [bpl_pkg::POS_W-1:0] pos;
		grow = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			held = shadow_list.size();
			if (held == bpl_pkg::DEPTH || held == 0) begin
				// linger a little at the ends to hit full and underflow
				if ($urandom_range(0, 2) == 0)
					grow = (held == 0);
			end else if ($urandom_range(0, 39) == 0)
				grow = ~grow;
			pick = $urandom_range(0, 99);
			if (pick < 3)
				op = pick[0] ? FN_SPARE7 : FN_SPARE6;
			else if (pick < (grow ? 70 : 33))
				op = 3'($urandom_range(bpl_pkg::FN_INS_FRONT, bpl_pkg::FN_INS_POS));
			else
				op = 3'($urandom_range(bpl_pkg::FN_DEL_FRONT, bpl_pkg::FN_DEL_POS));
			if ($urandom_range(0, 9) == 0)
				pos = 5'($urandom);
			else if (op == bpl_pkg::FN_INS_POS)
				pos = 5'($urandom_range(1, held + 1));
			else
				pos = 5'($urandom_range(1, (held > 0) ? held : 1));
			send_word(op, pos, pick_value());
		end
	endtask

	initial begin
		// every input known from time zero
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		out_ready = 1'b0;
		func      = '0;
		position  = '0;
		value     = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// slow receiver, mostly busy sender
		sender_idle_pct   = 23;
		receiver_idle_pct = 81;
		test_underflow();
		test_unused_codes();
		test_fill_list();
		test_full_list();
		test_deletes();
		test_random_mix(700);
		drain_results();

		// slow sender, mostly ready receiver
		sender_idle_pct   = 81;
		receiver_idle_pct = 23;
		test_random_mix(700);
		drain_results();

		// back to back, no idling either side
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		test_random_mix(600);
		drain_results();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_results.size() == 0)
			$display("** bounded_positional_list: PASSED **");
		else
			$display("** bounded_positional_list: FAILED **");
		$finish;
	end

endmodule
